>>> design/hcls_pkg.sv
package hcls_pkg;

    typedef logic [7:0]         char_t;
    typedef logic signed [31:0] length_t;
    typedef logic [4:0]         line_count_t;
    typedef logic [30:0]        tail_value_t;

    localparam line_count_t PREFIX_LEN = 5'd15;
    localparam line_count_t LINE_SAT   = 5'd31;

    localparam char_t CHAR_NEWLINE = 8'h0A;
    localparam char_t CHAR_SPACE   = 8'h20;
    localparam char_t CHAR_ZERO    = 8'h30;
    localparam char_t CHAR_NINE    = 8'h39;

    localparam tail_value_t LEN_MAX    = 31'h7FFF_FFFF;
    localparam length_t     LEN_ABSENT = -32'sd1;

    // Expected header name, one character per position on the line.
    function automatic char_t prefix_char(input logic [3:0] idx);
        char_t c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/hcls_byte_if.sv
interface hcls_byte_if
    import hcls_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t char_in;
    logic  end_of_request;

    modport source (output valid, output char_in, output end_of_request, input ready);
    modport sink   (input valid, input char_in, input end_of_request, output ready);
endinterface

>>> design/hcls_len_if.sv
interface hcls_len_if
    import hcls_pkg::*;
;
    logic    valid;
    logic    ready;
    length_t length_value;

    modport source (output valid, output length_value, input ready);
    modport sink   (input valid, input length_value, output ready);
endinterface

>>> design/http_content_length_scanner.sv
// Channel  Dir  Payload                        Transaction
// -------  ---  -----------------------------  ------------------------------------
// bytes    in   char_in[7:0], end_of_request   one request byte per transaction
// result   out  length_value[31:0] signed      one length per request, after last byte
//
// One byte is accepted every cycle unless both result slots are full; the
// per-line state is updated by a single level of logic (a shift-add by ten,
// a saturating compare, one 32-bit equality). A request's result is registered
// into the output register, or the skid slot while the output register is full.
// Two result slots (output register plus skid) let input flow while a result waits.
// rst_n clears all scanning state and empties both result slots.
module http_content_length_scanner
    import hcls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hcls_byte_if.sink   bytes,
    hcls_len_if.source  result
);

    // Request-wide state
    logic        error_seen_reg,      error_seen_next;
    logic        header_seen_reg,     header_seen_next;
    length_t     stored_length_reg,   stored_length_next;
    // Per-line state
    line_count_t line_chars_reg,      line_chars_next;
    logic        prefix_matches_reg,  prefix_matches_next;
    logic        tail_all_digits_reg, tail_all_digits_next;
    tail_value_t tail_acc_reg,        tail_acc_next;
    char_t       held_byte_reg,       held_byte_next;

    // Result slots
    logic        out_valid_reg,  out_valid_next;
    length_t     out_data_reg,   out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    length_t     skid_data_reg,  skid_data_next;

    logic        accept;
    logic        push;
    logic        pop;
    logic        is_newline;
    logic        is_space;
    logic        held_is_digit;
    logic [34:0] tail_times_ten;
    tail_value_t tail_digit_sum;
    logic        header_line;
    length_t     line_value;
    length_t     req_result;

    assign bytes.ready  = !skid_valid_reg;
    assign accept       = bytes.valid && bytes.ready;
    assign push         = accept && bytes.end_of_request;
    assign pop          = out_valid_reg && result.ready;

    assign result.valid        = out_valid_reg;
    assign result.length_value = out_data_reg;

    assign is_newline = (bytes.char_in == CHAR_NEWLINE);
    assign is_space   = (bytes.char_in == CHAR_SPACE);

    // Fold the previously held tail character into the decimal value:
    // acc * 10 + digit, computed as (acc << 3) + (acc << 1), saturated.
    assign held_is_digit  = (held_byte_reg >= CHAR_ZERO) && (held_byte_reg <= CHAR_NINE);
    assign tail_times_ten = {1'b0, tail_acc_reg, 3'b000} + {3'b000, tail_acc_reg, 1'b0}
                          + {31'd0, 4'(held_byte_reg - CHAR_ZERO)};
    assign tail_digit_sum = (tail_times_ten > {4'd0, LEN_MAX}) ? LEN_MAX
                                                               : tail_times_ten[30:0];

    // A terminated line that starts with the header name and has at least its length.
    assign header_line = (line_chars_reg >= PREFIX_LEN) && prefix_matches_reg;
    assign line_value  = tail_all_digits_reg ? length_t'({1'b0, tail_acc_reg}) : LEN_ABSENT;

    always_comb
    begin
        error_seen_next      = error_seen_reg;
        header_seen_next     = header_seen_reg;
        stored_length_next   = stored_length_reg;
        line_chars_next      = line_chars_reg;
        prefix_matches_next  = prefix_matches_reg;
        tail_all_digits_next = tail_all_digits_reg;
        tail_acc_next        = tail_acc_reg;
        held_byte_next       = held_byte_reg;

        if (accept)
        begin
            if (is_newline)
            begin
                // Close the line: check the header, then start a fresh line.
                if (header_line)
                begin
                    if (line_chars_reg == PREFIX_LEN)
                    begin
                        error_seen_next = 1'b1;
                    end
                    else if (!header_seen_reg)
                    begin
                        stored_length_next = line_value;
                        header_seen_next   = 1'b1;
                    end
                    else if (stored_length_reg != line_value)
                    begin
                        error_seen_next = 1'b1;
                    end
                end
                line_chars_next      = '0;
                prefix_matches_next  = 1'b1;
                tail_all_digits_next = 1'b1;
                tail_acc_next        = '0;
                held_byte_next       = '0;
            end
            else if (!is_space)
            begin
                if (line_chars_reg < PREFIX_LEN)
                begin
                    if (bytes.char_in != prefix_char(line_chars_reg[3:0]))
                    begin
                        prefix_matches_next = 1'b0;
                    end
                end
                else
                begin
                    // Hold each tail character one step: the last one is dropped.
                    if (line_chars_reg > PREFIX_LEN)
                    begin
                        if (held_is_digit)
                        begin
                            tail_acc_next = tail_digit_sum;
                        end
                        else
                        begin
                            tail_all_digits_next = 1'b0;
                        end
                    end
                    held_byte_next = bytes.char_in;
                end
                if (line_chars_reg < LINE_SAT)
                begin
                    line_chars_next = line_chars_reg + 5'd1;
                end
            end
        end

        req_result = (error_seen_next || !header_seen_next) ? LEN_ABSENT : stored_length_next;

        // Last byte: hand off the result and restart for the next request.
        if (push)
        begin
            error_seen_next      = 1'b0;
            header_seen_next     = 1'b0;
            stored_length_next   = LEN_ABSENT;
            line_chars_next      = '0;
            prefix_matches_next  = 1'b1;
            tail_all_digits_next = 1'b1;
            tail_acc_next        = '0;
            held_byte_next       = '0;
        end
    end

    // Output register with one skid slot behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = req_result;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_data_next  = req_result;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = req_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_seen_reg      <= 1'b0;
            header_seen_reg     <= 1'b0;
            stored_length_reg   <= LEN_ABSENT;
            line_chars_reg      <= '0;
            prefix_matches_reg  <= 1'b1;
            tail_all_digits_reg <= 1'b1;
            tail_acc_reg        <= '0;
            held_byte_reg       <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            error_seen_reg      <= error_seen_next;
            header_seen_reg     <= header_seen_next;
            stored_length_reg   <= stored_length_next;
            line_chars_reg      <= line_chars_next;
            prefix_matches_reg  <= prefix_matches_next;
            tail_all_digits_reg <= tail_all_digits_next;
            tail_acc_reg        <= tail_acc_next;
            held_byte_reg       <= held_byte_next;
            out_valid_reg       <= out_valid_next;
            skid_valid_reg      <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid slot fills only behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while output register is empty");

    // A request's last byte leaves the scanner in its idle state.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (line_chars_reg == '0) && !header_seen_reg && !error_seen_reg)
        else $error("scanner state not cleared after last byte");

    // Without a header the stored length keeps its absent marker.
    a_stored_absent: assert property (@(posedge clk) disable iff (!rst_n)
        !header_seen_reg |-> (stored_length_reg == LEN_ABSENT))
        else $error("stored length written without a header");

    // No tail characters are folded in while still inside the header name.
    a_tail_clear_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (line_chars_reg < PREFIX_LEN) |->
            (tail_acc_reg == '0) && tail_all_digits_reg && (held_byte_reg == '0))
        else $error("tail state changed before the header name ended");

endmodule

>>> bench/hcls_length_checker.sv
module hcls_length_checker
    import hcls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hcls_byte_if        bytes,
    hcls_len_if         result,
    output int unsigned mismatch_count,
    output int unsigned lengths_pending
);

    localparam logic [8*15-1:0] HEADER_NAME = "Content-Length:";

    // Scan state of the request in flight.
    logic        error_flag;
    logic        header_found;
    length_t     first_length;
    line_count_t line_count;
    logic        name_ok;
    logic        tail_numeric;
    logic [31:0] tail_value;
    char_t       held_char;

    length_t     expected_lengths [$];

    task automatic clear_line();
        line_count   = '0;
        name_ok      = 1'b1;
        tail_numeric = 1'b1;
        tail_value   = '0;
        held_char    = '0;
    endtask

    task automatic clear_request();
        error_flag   = 1'b0;
        header_found = 1'b0;
        first_length = LEN_ABSENT;
        clear_line();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        length_t         line_length;
        longint unsigned scaled;
        int              name_pos;
        char_t           c;
        length_t         got;
        if (!rst_n)
        begin
            clear_request();
            expected_lengths.delete();
            mismatch_count  <= 0;
            lengths_pending <= 0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
            begin
                c = bytes.char_in;
                if (c == CHAR_NEWLINE)
                begin
                    // Close the line: a header name alone is an error; with a tail its value counts.
                    if (line_count >= PREFIX_LEN && name_ok)
                    begin
                        if (line_count == PREFIX_LEN)
                            error_flag = 1'b1;
                        else
                        begin
                            line_length = tail_numeric ? length_t'(tail_value) : LEN_ABSENT;
                            if (!header_found)
                            begin
                                first_length = line_length;
                                header_found = 1'b1;
                            end
                            else if (first_length != line_length)
                                error_flag = 1'b1;
                        end
                    end
                    clear_line();
                end
                else if (c != CHAR_SPACE)
                begin
                    if (line_count < PREFIX_LEN)
                    begin
                        name_pos = 14 - int'(line_count);
                        if (c != HEADER_NAME[8*name_pos +: 8])
                            name_ok = 1'b0;
                    end
                    else
                    begin
                        // Fold in the held character; the newest one may be the last.
                        if (line_count > PREFIX_LEN)
                        begin
                            if (held_char >= CHAR_ZERO && held_char <= CHAR_NINE)
                            begin
                                scaled = 64'(tail_value) * 64'd10 + 64'(held_char - CHAR_ZERO);
                                tail_value = (scaled > 64'(LEN_MAX)) ? 32'(LEN_MAX)
                                                                     : scaled[31:0];
                            end
                            else
                                tail_numeric = 1'b0;
                        end
                        held_char = c;
                    end
                    if (line_count < LINE_SAT)
                        line_count = line_count + 1'b1;
                end
                if (bytes.end_of_request)
                begin
                    expected_lengths.push_back((error_flag || !header_found) ? LEN_ABSENT
                                                                             : first_length);
                    clear_request();
                end
            end
            if (result.valid && result.ready)
            begin
                got = result.length_value;
                if (expected_lengths.size() == 0)
                begin
                    $error("length_value: expected no result, got %0d", got);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    if (got !== expected_lengths[0])
                    begin
                        $error("length_value: expected %0d, got %0d", expected_lengths[0], got);
                        mismatch_count <= mismatch_count + 1;
                    end
                    void'(expected_lengths.pop_front());
                end
            end
            lengths_pending <= expected_lengths.size();
        end
    end

endmodule

>>> bench/http_content_length_scanner_test.sv
module http_content_length_scanner_test;
    import hcls_pkg::*;

    localparam char_t CHAR_CR = 8'h0D;

    // One byte of the request stream as it goes out on the byte channel.
    typedef struct packed {
        char_t c;
        logic  last;
    } stream_byte_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatch_count;
    int unsigned lengths_pending;

    hcls_byte_if bytes ();
    hcls_len_if  result ();

    // Whole stimulus stream, built before reset is released.
    stream_byte_t request_stream [$];
    // Request under construction; moved into the stream when it is closed.
    char_t        request_text [$];
    int unsigned  request_count;
    // Chance (one in space_odds) of a dropped space ahead of each text byte; zero for none.
    int unsigned  space_odds;

    http_content_length_scanner i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .result (result)
    );

    hcls_length_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .bytes           (bytes),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .lengths_pending (lengths_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append text, sprinkling in spaces that the block must drop.
    task automatic push_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
        begin
            if (space_odds != 0 && $urandom_range(space_odds - 1) == 0)
                request_text.push_back(CHAR_SPACE);
            request_text.push_back(char_t'(text[i]));
        end
    endtask

    // Terminate the current line, with or without a carriage return.
    task automatic end_line(input bit with_cr);
        if (with_cr)
            request_text.push_back(CHAR_CR);
        request_text.push_back(CHAR_NEWLINE);
    endtask

    task automatic add_length_line(input string tail, input bit with_cr);
        push_text("Content-Length:");
        push_text(tail);
        end_line(with_cr);
    endtask

    // Flag the final byte and move the request into the stream.
    task automatic close_request();
        stream_byte_t b;
        if (request_text.size() == 0)
            request_text.push_back(char_t'($urandom_range(0, 255)));
        while (request_text.size() > 0)
        begin
            b.c    = request_text.pop_front();
            b.last = (request_text.size() == 0);
            request_stream.push_back(b);
        end
        request_count++;
    endtask

    // Mostly short values, some full 32-bit ones, leading zeros, and overlong
    // digit runs that may saturate.
    function automatic string random_length_text();
        int unsigned pick;
        string       text;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            text = $sformatf("%0d", $urandom_range(0, 99999));
        else if (pick < 8)
            text = $sformatf("%0d", $urandom);
        else if (pick < 9)
            text = {"00", $sformatf("%0d", $urandom_range(0, 999))};
        else
        begin
            text = "";
            repeat ($urandom_range(10, 16))
                text = {text, $sformatf("%0d", $urandom_range(0, 9))};
        end
        return text;
    endfunction

    // A random request: header lines mostly carrying one agreed value, mixed
    // with broken headers, other headers, near misses of the name and noise.
    task automatic add_random_request();
        int unsigned pick;
        string       agreed;
        string       name;
        char_t       odd;
        space_odds = ($urandom_range(0, 2) == 0) ? 4 : 0;
        agreed     = random_length_text();
        repeat ($urandom_range(0, 4))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_length_line(($urandom_range(0, 4) == 0) ? random_length_text() : agreed,
                                $urandom_range(0, 9) != 0);
            else if (pick < 50)
            begin
                case ($urandom_range(0, 2))
                    0: add_length_line("", 1'b0);
                    1: add_length_line("", 1'b1);
                    default:
                    begin
                        // Plant one non-digit in the tail.
                        odd = char_t'($urandom_range(0, 255));
                        if (odd == CHAR_NEWLINE || (odd >= CHAR_ZERO && odd <= CHAR_NINE))
                            odd = "#";
                        push_text("Content-Length:");
                        push_text(agreed);
                        request_text.push_back(odd);
                        push_text($sformatf("%0d", $urandom_range(0, 99)));
                        end_line(1'b1);
                    end
                endcase
            end
            else if (pick < 75)
            begin
                case ($urandom_range(0, 3))
                    0:       push_text("Host:example");
                    1:       push_text("Accept:*/*");
                    2:       push_text({"Content-Lengths:", agreed});
                    default: push_text({"Content-Length", agreed});
                endcase
                end_line(1'b1);
            end
            else if (pick < 87)
            begin
                // Overwrite one character of the header name with a random byte.
                name = "Content-Length:";
                odd  = char_t'($urandom_range(0, 255));
                if (odd == CHAR_NEWLINE)
                    odd = "c";
                name[$urandom_range(0, 14)] = odd;
                push_text(name);
                push_text(agreed);
                end_line(1'b1);
            end
            else
            begin
                repeat ($urandom_range(0, 12))
                    request_text.push_back(char_t'($urandom_range(0, 255)));
                request_text.push_back(CHAR_NEWLINE);
            end
        end
        if ($urandom_range(0, 1) == 0)
            end_line(1'b1);
        // Leave a trailing line without its newline now and then.
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                push_text({"Content-Length:", random_length_text()});
            else
                repeat ($urandom_range(1, 6))
                    request_text.push_back(char_t'($urandom_range(0, 255)));
        end
        close_request();
    endtask

    // Build the stream, release reset, then feed the byte channel in bursts
    // with random gaps, holding each transaction until it is accepted.
    initial
    begin : stimulus
        stream_byte_t next_byte;
        int unsigned  burst_left;
        int unsigned  gap_left;

        bytes.valid          <= 1'b0;
        bytes.char_in        <= '0;
        bytes.end_of_request <= 1'b0;

        space_odds = 0;
        // Plain header; the request ends on the newline of the blank line.
        add_length_line("42", 1'b1);
        end_line(1'b1);
        close_request();
        // Tail of a single character reads as zero.
        add_length_line("", 1'b1);
        close_request();
        // Empty tail: the line is the header name alone.
        add_length_line("", 1'b0);
        close_request();
        // Non-digit in the tail.
        add_length_line("12a", 1'b1);
        close_request();
        // Repeated header: agreeing, then disagreeing.
        add_length_line("5", 1'b1);
        add_length_line("5", 1'b1);
        close_request();
        add_length_line("5", 1'b1);
        add_length_line("6", 1'b1);
        close_request();
        // Two invalid values agree with each other.
        add_length_line("x", 1'b1);
        add_length_line("y", 1'b1);
        close_request();
        // Largest value, one above it, and a tail past the line counter's range.
        add_length_line("2147483647", 1'b1);
        close_request();
        add_length_line("2147483648", 1'b1);
        close_request();
        add_length_line("99999999999999999999", 1'b1);
        close_request();
        // Header name in the wrong case.
        push_text("content-length:7");
        end_line(1'b1);
        close_request();
        // No length header at all.
        push_text("Host:a");
        end_line(1'b1);
        close_request();
        // Unterminated final line is ignored.
        add_length_line("9", 1'b1);
        push_text("Content-Length:8");
        close_request();
        // Without a carriage return the last digit is dropped.
        add_length_line("34", 1'b0);
        close_request();
        // Spaces anywhere on the line are dropped.
        space_odds = 2;
        add_length_line("12", 1'b1);
        space_odds = 0;
        close_request();
        // Extreme byte values, then a request that is a lone newline.
        request_text.push_back(8'h00);
        request_text.push_back(8'hFF);
        close_request();
        end_line(1'b0);
        close_request();

        while (request_stream.size() < 1400 || request_count < 60)
            add_random_request();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        burst_left = $urandom_range(1, 60);
        gap_left   = 0;
        forever
        begin
            @(posedge clk);
            // Hold a transaction that has not been taken yet.
            if (!bytes.valid || bytes.ready)
            begin
                if (request_stream.size() == 0)
                begin
                    bytes.valid <= 1'b0;
                    break;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    bytes.valid <= 1'b0;
                end
                else
                begin
                    next_byte = request_stream.pop_front();
                    bytes.valid          <= 1'b1;
                    bytes.char_in        <= next_byte.c;
                    bytes.end_of_request <= next_byte.last;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30)
                                                                 : $urandom_range(1, 6);
                    end
                end
            end
        end

        // Let the last expectation be registered, drain, then wait on for any
        // stray result to show up.
        @(posedge clk);
        while (lengths_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: alternate free-flowing stretches with random stalls, and
    // twice hold off long enough for both result slots to fill and the byte
    // channel to back up.
    initial
    begin : drain
        int unsigned cycle_count;
        int unsigned hold_left;
        int unsigned phase_left;
        int unsigned stall_odds;

        cycle_count = 0;
        hold_left   = 0;
        phase_left  = 0;
        stall_odds  = 0;
        result.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == 600 || cycle_count == 2500)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0:       stall_odds = 0;
                        1:       stall_odds = 2;
                        2:       stall_odds = 4;
                        default: stall_odds = 8;
                    endcase
                end
                phase_left--;
                result.ready <= (stall_odds == 0) || ($urandom_range(stall_odds - 1) != 0);
            end
        end
    end

    // Drop the run if it hangs.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
